// ----- src/apt_pkg.sv -----
// Package for the avoidance zone table: payload types, codes and defaults.
package apt_pkg;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 16;

  // Operation codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_SAME      = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_ADDED     = 3'd2,
    ST_FULL      = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  // Input transaction
  typedef struct packed {
    logic        operation;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [15:0] radius;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    status_t     status;
    logic        changed;
    logic [4:0]  entry_count;
  } out_item_t;

  // One stored zone
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] r;
  } zone_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic compare;
    logic execute;
  } cmd_t;

endpackage

// ----- src/apt_ctrl.sv -----
// Controller for the avoidance zone table: sequencing and handshakes.
module apt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output apt_pkg::cmd_t cmd
);

  apt_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // Output register can take a result this cycle
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      apt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = apt_pkg::S_CMP;
      end
      apt_pkg::S_CMP: begin
        state_nxt = apt_pkg::S_EXEC;
      end
      apt_pkg::S_EXEC: begin
        if (out_free) state_nxt = in_valid ? apt_pkg::S_CMP : apt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = apt_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: a new transaction may enter as the current one retires
  always_comb begin
    in_stall    = 1'b1;
    cmd.compare = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      apt_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      apt_pkg::S_CMP: begin
        cmd.compare = 1'b1;
      end
      apt_pkg::S_EXEC: begin
        in_stall    = !out_free;
        cmd.execute = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    cmd.load = in_valid && !in_stall;
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/apt_dpath.sv -----
// Datapath for the avoidance zone table: zone lanes, match logic, result register.
module apt_dpath #(
  parameter int TABLE_ENTRIES = apt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  apt_pkg::cmd_t      cmd,
  input  apt_pkg::in_item_t  in_data,
  output apt_pkg::out_item_t out_data
);

  localparam int N  = TABLE_ENTRIES;
  localparam int CW = $clog2(N + 1);
  localparam int EW = CW + 5;

  apt_pkg::in_item_t  cmd_item_r;
  apt_pkg::zone_t     zone_r   [N];
  apt_pkg::zone_t     zone_nxt [N];
  logic [CW-1:0]      count_r, count_nxt;
  logic [N-1:0]       lane_valid, match, rmatch, low_bit, ge_mask;
  logic [N-1:0]       low_r, ge_r;
  logic               hit_r, same_r;
  logic               is_remove;
  apt_pkg::status_t   status;
  logic [EW-1:0]      count_ext;
  apt_pkg::out_item_t out_item_r;

  // Command register, taken on each accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) cmd_item_r <= in_data;
  end

  assign is_remove = (cmd_item_r.operation == apt_pkg::OP_REMOVE);

  // Per-lane valid and centre/radius compare
  for (genvar i = 0; i < N; i++) begin : g_cmp
    assign lane_valid[i] = (CW'(i) < count_r);
    assign match[i]  = lane_valid[i] && (zone_r[i].x == cmd_item_r.point_x)
                       && (zone_r[i].y == cmd_item_r.point_y);
    assign rmatch[i] = (zone_r[i].r == cmd_item_r.radius);
  end

  // First hit and the mask of lanes at or above it
  assign low_bit = match & (~match + N'(1));
  assign ge_mask = ~(low_bit - N'(1));

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      low_r  <= low_bit;
      ge_r   <= ge_mask;
      hit_r  <= |match;
      same_r <= |(low_bit & rmatch);
    end
  end

  // Status and count for the transaction being retired
  always_comb begin
    status    = apt_pkg::ST_SAME;
    count_nxt = count_r;
    if (is_remove) begin
      if (hit_r) begin
        status    = apt_pkg::ST_REMOVED;
        count_nxt = count_r - CW'(1);
      end else begin
        status = apt_pkg::ST_NOT_FOUND;
      end
    end else if (hit_r) begin
      status = same_r ? apt_pkg::ST_SAME : apt_pkg::ST_UPDATED;
    end else if (count_r == CW'(N)) begin
      status = apt_pkg::ST_FULL;
    end else begin
      status    = apt_pkg::ST_ADDED;
      count_nxt = count_r + CW'(1);
    end
  end

  // Lane update: radius rewrite, append at the count, or shift down on remove
  for (genvar i = 0; i < N; i++) begin : g_lane
    apt_pkg::zone_t shift_src;
    if (i < N - 1) begin : g_up
      assign shift_src = zone_r[i+1];
    end else begin : g_top
      assign shift_src = zone_r[i];
    end

    always_comb begin
      zone_nxt[i] = zone_r[i];
      if (status == apt_pkg::ST_UPDATED && low_r[i]) begin
        zone_nxt[i].r = cmd_item_r.radius;
      end else if (status == apt_pkg::ST_ADDED && count_r == CW'(i)) begin
        zone_nxt[i].x = cmd_item_r.point_x;
        zone_nxt[i].y = cmd_item_r.point_y;
        zone_nxt[i].r = cmd_item_r.radius;
      end else if (status == apt_pkg::ST_REMOVED && ge_r[i]) begin
        zone_nxt[i] = shift_src;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.execute) zone_r[i] <= zone_nxt[i];
    end
  end

  // Entry count; empty after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  assign count_ext = EW'(count_nxt);

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_item_r.status      <= status;
      out_item_r.changed     <= (status == apt_pkg::ST_UPDATED) ||
                                (status == apt_pkg::ST_ADDED) ||
                                (status == apt_pkg::ST_REMOVED);
      out_item_r.entry_count <= count_ext[4:0];
    end
  end

  assign out_data = out_item_r;

endmodule

// ----- src/avoid_point_table.sv -----
// Top level of the avoidance zone table: controller plus datapath.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   apt_pkg::in_item_t  in_data
//   out_     output     out_valid / out_stall apt_pkg::out_item_t out_data
//
// Each transaction passes a compare state (centre checked against every lane,
// first hit registered), then an execute state (update applied, result register
// loaded). A new transaction is taken in the cycle the previous one retires.
// Reset empties the table (entry count to zero) at once; no clearing pass.
// A stalled result holds in its register; a transaction whose compare is done
// waits in the execute state, input stalled, until the result register frees.
module avoid_point_table #(
  parameter int TABLE_ENTRIES = apt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  apt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output apt_pkg::out_item_t out_data
);

  apt_pkg::cmd_t cmd;

  apt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  apt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the avoidance zone table: directed rows, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ZONES   = apt_pkg::TABLE_ENTRIES_DEF;
  localparam int N_RANDOM  = 500;
  localparam int POOL_SIZE = 20;

  // One row of the directed stimulus table
  typedef struct {
    apt_pkg::in_item_t  item;
    bit                 typed;
    apt_pkg::out_item_t want;
  } zone_row_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  apt_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  apt_pkg::out_item_t out_data;

  // Shadow copy of the zone table
  apt_pkg::zone_t     shadow_zone [N_ZONES];
  bit                 shadow_live [N_ZONES];

  apt_pkg::out_item_t pending_results [$];
  zone_row_t          zone_rows [$];
  logic [15:0]        pool_x [POOL_SIZE];
  logic [15:0]        pool_y [POOL_SIZE];
  logic [15:0]        radius_set [5];

  bit quiet = 1'b0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int seen_status [6];

  avoid_point_table #(.TABLE_ENTRIES(N_ZONES)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Apply one transaction to the shadow table and return the result it gives
  function automatic apt_pkg::out_item_t predict_zone_op(apt_pkg::in_item_t it);
    apt_pkg::out_item_t res;
    apt_pkg::status_t   st;
    int                 i;
    int                 hit;
    int                 n;
    bit                 done;
    st   = apt_pkg::ST_FULL;
    done = 1'b0;
    if (it.operation == apt_pkg::OP_ADD) begin
      for (i = 0; i < N_ZONES && !done; i++) begin
        if (!shadow_live[i]) begin
          shadow_zone[i] = {it.point_x, it.point_y, it.radius};
          shadow_live[i] = 1'b1;
          st   = apt_pkg::ST_ADDED;
          done = 1'b1;
        end else if (shadow_zone[i].x == it.point_x && shadow_zone[i].y == it.point_y) begin
          st = (shadow_zone[i].r == it.radius) ? apt_pkg::ST_SAME : apt_pkg::ST_UPDATED;
          shadow_zone[i].r = it.radius;
          done = 1'b1;
        end
      end
    end else begin
      hit = -1;
      for (i = 0; i < N_ZONES && hit < 0; i++) begin
        if (shadow_live[i] && shadow_zone[i].x == it.point_x &&
            shadow_zone[i].y == it.point_y) begin
          hit = i;
        end
      end
      if (hit < 0) begin
        st = apt_pkg::ST_NOT_FOUND;
      end else begin
        // close the gap: later entries move down one slot
        i = hit;
        while (i + 1 < N_ZONES && shadow_live[i + 1]) begin
          shadow_zone[i] = shadow_zone[i + 1];
          i++;
        end
        shadow_live[i] = 1'b0;
        st = apt_pkg::ST_REMOVED;
      end
    end
    n = 0;
    for (i = 0; i < N_ZONES; i++) begin
      if (shadow_live[i]) begin
        n++;
      end
    end
    res.status      = st;
    res.changed     = (st == apt_pkg::ST_UPDATED || st == apt_pkg::ST_ADDED ||
                       st == apt_pkg::ST_REMOVED);
    res.entry_count = 5'(n);
    return res;
  endfunction

  task automatic add_row(logic op, logic [15:0] x, logic [15:0] y, logic [15:0] r,
                         bit typed, apt_pkg::status_t st, logic ch, logic [4:0] cnt);
    zone_row_t row;
    row.item  = {op, x, y, r};
    row.typed = typed;
    row.want  = '{status: st, changed: ch, entry_count: cnt};
    zone_rows.push_back(row);
  endtask

  // Coordinate for the random pool, biased towards the extremes
  function automatic logic [15:0] pool_coord();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return 16'h0000;
    end else if (pick == 1) begin
      return 16'hffff;
    end
    return 16'($urandom);
  endfunction

  // Random transaction: mostly pool points and known radii, some pure noise
  function automatic apt_pkg::in_item_t random_zone_item(int idx);
    apt_pkg::in_item_t it;
    int                phase;
    int                add_pct;
    int                sel;
    int                live_n;
    phase   = (idx / 60) % 3;
    add_pct = (phase == 0) ? 85 : (phase == 1) ? 25 : 55;
    if ($urandom_range(99) < 10) begin
      it.operation = 1'($urandom_range(1));
      it.point_x   = 16'($urandom);
      it.point_y   = 16'($urandom);
      it.radius    = 16'($urandom);
      return it;
    end
    it.operation = ($urandom_range(99) < add_pct) ? apt_pkg::OP_ADD : apt_pkg::OP_REMOVE;
    sel = $urandom_range(POOL_SIZE - 1);
    it.point_x = pool_x[sel];
    it.point_y = pool_y[sel];
    it.radius  = ($urandom_range(99) < 20) ? 16'($urandom) : radius_set[$urandom_range(4)];
    // removes mostly aim at a stored centre so the table drains
    live_n = 0;
    for (int i = 0; i < N_ZONES; i++) begin
      if (shadow_live[i]) begin
        live_n++;
      end
    end
    if (it.operation == apt_pkg::OP_REMOVE && live_n > 0 && $urandom_range(99) < 70) begin
      sel = $urandom_range(live_n - 1);
      it.point_x = shadow_zone[sel].x;
      it.point_y = shadow_zone[sel].y;
    end
    return it;
  endfunction

  // Random idle gap on the input side
  task automatic maybe_idle();
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Offer one transaction and record its expected result once accepted
  task automatic send_txn(apt_pkg::in_item_t it, bit typed, apt_pkg::out_item_t want);
    apt_pkg::out_item_t pred;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pred = predict_zone_op(it);
    pending_results.push_back(typed ? want : pred);
    n_sent++;
  endtask

  // Result side: check each transaction and stall at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin : rx_chk
        apt_pkg::out_item_t want;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (out_data.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
          end
          if (out_data.changed !== want.changed) begin
            report_mismatch($sformatf("changed %0b, expected %0b",
                                      out_data.changed, want.changed));
          end
          if (out_data.entry_count !== want.entry_count) begin
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      out_data.entry_count, want.entry_count));
          end
          if (out_data.status <= apt_pkg::ST_NOT_FOUND) begin
            seen_status[out_data.status]++;
          end
        end
      end
      out_stall <= (!quiet && $urandom_range(99) < 25);
    end
  end

  // Stimulus
  initial begin
    int k;
    int sel;
    for (k = 0; k < N_ZONES; k++) begin
      shadow_live[k] = 1'b0;
      shadow_zone[k] = '0;
    end
    for (k = 0; k < 6; k++) begin
      seen_status[k] = 0;
    end

    // directed table: empty table, extremes, update, compaction, full table
    add_row(apt_pkg::OP_REMOVE, 16'h0000, 16'h0000, 16'h0000, 1,
            apt_pkg::ST_NOT_FOUND, 1'b0, 5'd0);
    add_row(apt_pkg::OP_ADD,    16'h0000, 16'h0000, 16'h0000, 1,
            apt_pkg::ST_ADDED,     1'b1, 5'd1);
    add_row(apt_pkg::OP_ADD,    16'h0000, 16'h0000, 16'h0000, 1,
            apt_pkg::ST_SAME,      1'b0, 5'd1);
    add_row(apt_pkg::OP_ADD,    16'h0000, 16'h0000, 16'hffff, 1,
            apt_pkg::ST_UPDATED,   1'b1, 5'd1);
    add_row(apt_pkg::OP_ADD,    16'hffff, 16'hffff, 16'hffff, 1,
            apt_pkg::ST_ADDED,     1'b1, 5'd2);
    add_row(apt_pkg::OP_ADD,    16'hffff, 16'h0000, 16'h1234, 1,
            apt_pkg::ST_ADDED,     1'b1, 5'd3);
    add_row(apt_pkg::OP_ADD,    16'h0000, 16'hffff, 16'habcd, 1,
            apt_pkg::ST_ADDED,     1'b1, 5'd4);
    // radius is ignored on remove
    add_row(apt_pkg::OP_REMOVE, 16'h0000, 16'hffff, 16'h5555, 1,
            apt_pkg::ST_REMOVED,   1'b1, 5'd3);
    add_row(apt_pkg::OP_REMOVE, 16'h0000, 16'hffff, 16'h0000, 1,
            apt_pkg::ST_NOT_FOUND, 1'b0, 5'd3);
    add_row(apt_pkg::OP_REMOVE, 16'h0000, 16'h0000, 16'hffff, 1,
            apt_pkg::ST_REMOVED,   1'b1, 5'd2);
    for (k = 3; k <= N_ZONES; k++) begin
      add_row(apt_pkg::OP_ADD, 16'(k * 257), ~16'(k * 257), 16'(k), 1,
              apt_pkg::ST_ADDED, 1'b1, 5'(k));
    end
    add_row(apt_pkg::OP_ADD,    16'h0001, 16'h0001, 16'h0001, 1,
            apt_pkg::ST_FULL,      1'b0, 5'(N_ZONES));
    add_row(apt_pkg::OP_ADD,    16'(9 * 257), ~16'(9 * 257), 16'h9999, 0,
            apt_pkg::ST_SAME, 1'b0, 5'd0);
    add_row(apt_pkg::OP_REMOVE, 16'(9 * 257), ~16'(9 * 257), 16'h0000, 0,
            apt_pkg::ST_SAME, 1'b0, 5'd0);
    add_row(apt_pkg::OP_ADD,    16'hffff, 16'hffff, 16'hffff, 0,
            apt_pkg::ST_SAME,      1'b0, 5'd0);

    for (k = 0; k < POOL_SIZE; k++) begin
      pool_x[k] = pool_coord();
      pool_y[k] = pool_coord();
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (zone_rows[k]) begin
      maybe_idle();
      send_txn(zone_rows[k].item, zone_rows[k].typed, zone_rows[k].want);
    end

    for (k = 0; k < N_RANDOM; k++) begin
      // fresh radii and a few new centres each phase
      if (k % 60 == 0) begin
        radius_set[0] = 16'h0000;
        radius_set[1] = 16'hffff;
        for (int j = 2; j < 5; j++) begin
          radius_set[j] = 16'($urandom);
        end
        if (k != 0) begin
          repeat (5) begin
            sel = $urandom_range(POOL_SIZE - 1);
            pool_x[sel] = pool_coord();
            pool_y[sel] = pool_coord();
          end
        end
      end
      quiet = (k >= 250 && k < 350);
      maybe_idle();
      send_txn(random_zone_item(k), 1'b0, '0);
    end

    in_valid <= 1'b0;
    quiet = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d transactions sent, %0d results checked (%0d directed rows)",
             n_sent, n_checked, zone_rows.size());
    $display("status mix: same %0d, updated %0d, added %0d, full %0d, removed %0d, absent %0d",
             seen_status[apt_pkg::ST_SAME], seen_status[apt_pkg::ST_UPDATED],
             seen_status[apt_pkg::ST_ADDED], seen_status[apt_pkg::ST_FULL],
             seen_status[apt_pkg::ST_REMOVED], seen_status[apt_pkg::ST_NOT_FOUND]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/apt_pkg.sv
src/apt_ctrl.sv
src/apt_dpath.sv
src/avoid_point_table.sv
tb/tb_top.sv
